// ----- hw/rtl/i2da_pkg.sv -----
// ----------------------------------------------------------------------------
// i2da_pkg
// Shared constants and types for the integer to decimal ASCII converter.
// ----------------------------------------------------------------------------
package i2da_pkg;

    // Binary input width and decimal digit count (2^64-1 has 20 digits)
    localparam int VALUE_W    = 64;
    localparam int DIGITS     = 20;
    localparam int BCD_W      = 4;
    localparam int CHAR_W     = 8;
    localparam int BIT_CNT_W  = $clog2(VALUE_W);
    localparam int DIG_CNT_W  = $clog2(DIGITS + 1);

    // Character codes
    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] ASCII_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;

    // Mode codes
    localparam logic CMD_UNSIGNED = 1'b0;
    localparam logic CMD_SIGNED   = 1'b1;

    // BCD digit vector, most significant digit at the top index
    typedef logic [DIGITS-1:0][BCD_W-1:0] bcd_vec_t;

    // Result handed from the shift converter to the character emitter
    typedef struct packed {
        logic     neg;
        bcd_vec_t bcd;
    } dab_result_t;

endpackage

// ----- hw/rtl/integer_to_decimal_ascii_top.sv -----
// ----------------------------------------------------------------------------
// integer_to_decimal_ascii_top
// Converts a 64-bit unsigned or two's complement value to decimal ASCII
// text, one character per output beat, most significant first.
// ----------------------------------------------------------------------------
//  Channel | Handshake            | Payload
//  --------+----------------------+----------------------------------------
//  in      | in_valid / in_stall  | command (1), value (64)
//  out     | out_valid / out_stall| character (8), is_last (1)
//
//  A number passes through the bit-serial BCD shifter one value bit per
//  cycle, between a load step and a handoff to the emitter.
//  The emitter then drains the sign and digits, overlapped with the next
//  number's shifting.
//  Reset clears all control state; nothing further is needed after reset.
//  in_stall is high while the shifter is busy or holds an untaken result;
//  out_stall holds the output beat and pauses the emitter.
// ----------------------------------------------------------------------------
module integer_to_decimal_ascii_top
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              command,
    input  logic [i2da_pkg::VALUE_W-1:0]      value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [i2da_pkg::CHAR_W-1:0]       character,
    output logic                              is_last
);

    logic                              dab_ready;
    logic                              load;
    logic                              neg;
    logic [i2da_pkg::VALUE_W-1:0]      mag;
    logic                              res_valid;
    logic                              res_take;
    i2da_pkg::dab_result_t             res;

    // Sign and magnitude; the most negative value negates to itself, which
    // is the correct unsigned magnitude
    assign neg  = (command == i2da_pkg::CMD_SIGNED) && value[i2da_pkg::VALUE_W-1];
    assign mag  = neg ? (~value + 1'b1) : value;
    assign load = in_valid && dab_ready;

    assign in_stall = !dab_ready;

    i2da_dabble u_dabble
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .load_neg  (neg),
        .load_mag  (mag),
        .ready     (dab_ready),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res       (res)
    );

    i2da_emit u_emit
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res       (res),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .character (character),
        .is_last   (is_last)
    );

endmodule

// ----- hw/rtl/i2da_dabble.sv -----
// ----------------------------------------------------------------------------
// i2da_dabble
// Bit-serial binary to BCD converter (shift and add-3), one bit per cycle.
// ----------------------------------------------------------------------------
module i2da_dabble
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              load,
    input  logic                              load_neg,
    input  logic [i2da_pkg::VALUE_W-1:0]      load_mag,
    output logic                              ready,
    output logic                              res_valid,
    input  logic                              res_take,
    output i2da_pkg::dab_result_t             res
);

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_RUN,
        ST_HOLD
    } state_t;

    state_t                              state_reg;
    logic [i2da_pkg::VALUE_W-1:0]        mag_reg;
    i2da_pkg::bcd_vec_t                  bcd_reg;
    i2da_pkg::bcd_vec_t                  bcd_next;
    i2da_pkg::bcd_vec_t                  bcd_adj;
    logic [i2da_pkg::DIGITS*i2da_pkg::BCD_W-1:0] bcd_flat;
    logic [i2da_pkg::BIT_CNT_W-1:0]      count_reg;
    logic                                neg_reg;

    // Add 3 to every digit of 5 or more, then shift in the next magnitude bit
    always_comb
    begin
        for (int i = 0; i < i2da_pkg::DIGITS; i++)
        begin
            if (bcd_reg[i] >= 4'd5)
            begin
                bcd_adj[i] = bcd_reg[i] + 4'd3;
            end
            else
            begin
                bcd_adj[i] = bcd_reg[i];
            end
        end
        bcd_flat = bcd_adj;
        bcd_next = {bcd_flat[i2da_pkg::DIGITS*i2da_pkg::BCD_W-2:0],
                    mag_reg[i2da_pkg::VALUE_W-1]};
    end

    // Sequencer and shift registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            mag_reg   <= '0;
            bcd_reg   <= '0;
            count_reg <= '0;
            neg_reg   <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (load)
                    begin
                        mag_reg   <= load_mag;
                        neg_reg   <= load_neg;
                        bcd_reg   <= '0;
                        count_reg <= '0;
                        state_reg <= ST_RUN;
                    end
                end
                ST_RUN:
                begin
                    bcd_reg   <= bcd_next;
                    mag_reg   <= {mag_reg[i2da_pkg::VALUE_W-2:0], 1'b0};
                    count_reg <= count_reg + 1'b1;
                    if (count_reg == i2da_pkg::BIT_CNT_W'(i2da_pkg::VALUE_W - 1))
                    begin
                        state_reg <= ST_HOLD;
                    end
                end
                ST_HOLD:
                begin
                    if (res_take)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign ready     = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_HOLD);
    assign res.neg   = neg_reg;
    assign res.bcd   = bcd_reg;

endmodule

// ----- hw/rtl/i2da_emit.sv -----
// ----------------------------------------------------------------------------
// i2da_emit
// Digit-serial character emitter: sign, then BCD digits most significant
// first with leading zeros dropped, into a registered output beat.
// ----------------------------------------------------------------------------
module i2da_emit
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              res_valid,
    output logic                              res_take,
    input  i2da_pkg::dab_result_t             res,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [i2da_pkg::CHAR_W-1:0]       character,
    output logic                              is_last
);

    typedef enum logic
    {
        ST_IDLE,
        ST_BUSY
    } state_t;

    state_t                              state_reg;
    i2da_pkg::bcd_vec_t                  digits_reg;
    logic [i2da_pkg::DIG_CNT_W-1:0]      remain_reg;
    logic                                neg_pend_reg;
    logic                                started_reg;
    logic                                out_valid_reg;
    logic [i2da_pkg::CHAR_W-1:0]         char_reg;
    logic                                last_reg;

    logic                                slot_free;
    logic [i2da_pkg::BCD_W-1:0]          top_digit;
    logic                                final_digit;
    logic                                show_digit;

    assign slot_free   = !out_valid_reg || !out_stall;
    assign top_digit   = digits_reg[i2da_pkg::DIGITS-1];
    assign final_digit = (remain_reg == i2da_pkg::DIG_CNT_W'(1));
    assign show_digit  = started_reg || (top_digit != '0) || final_digit;
    assign res_take    = (state_reg == ST_IDLE) && res_valid;

    // State and output beat register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            digits_reg    <= '0;
            remain_reg    <= '0;
            neg_pend_reg  <= 1'b0;
            started_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            char_reg      <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (slot_free)
                    begin
                        out_valid_reg <= 1'b0;
                    end
                    if (res_take)
                    begin
                        digits_reg   <= res.bcd;
                        neg_pend_reg <= res.neg;
                        remain_reg   <= i2da_pkg::DIG_CNT_W'(i2da_pkg::DIGITS);
                        started_reg  <= 1'b0;
                        state_reg    <= ST_BUSY;
                    end
                end
                ST_BUSY:
                begin
                    if (slot_free)
                    begin
                        if (neg_pend_reg)
                        begin
                            // sign beat goes out first
                            out_valid_reg <= 1'b1;
                            char_reg      <= i2da_pkg::ASCII_MINUS;
                            last_reg      <= 1'b0;
                            neg_pend_reg  <= 1'b0;
                        end
                        else
                        begin
                            // leading zeros are shifted out and emit nothing
                            out_valid_reg <= show_digit;
                            char_reg      <= i2da_pkg::ASCII_ZERO
                                             | {{(i2da_pkg::CHAR_W-i2da_pkg::BCD_W){1'b0}},
                                                top_digit};
                            last_reg      <= final_digit;
                            started_reg   <= show_digit;
                            digits_reg    <= {digits_reg[i2da_pkg::DIGITS-2:0],
                                              {i2da_pkg::BCD_W{1'b0}}};
                            remain_reg    <= remain_reg - 1'b1;
                            if (final_digit)
                            begin
                                state_reg <= ST_IDLE;
                            end
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign character = char_reg;
    assign is_last   = last_reg;

endmodule

// ----- hw/rtl/i2da_checker.sv -----
// ----------------------------------------------------------------------------
// i2da_checker
// Port-level checks for the integer to decimal ASCII converter.
// ----------------------------------------------------------------------------
module i2da_checker
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_stall,
    input  logic                              out_valid,
    input  logic                              out_stall,
    input  logic [i2da_pkg::CHAR_W-1:0]       character,
    input  logic                              is_last
);

    // A stalled output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(character) && $stable(is_last))
        else $error("output beat changed while stalled");

    // Only a sign or a decimal digit ever leaves
    a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (character == i2da_pkg::ASCII_MINUS)
                      || (character >= i2da_pkg::ASCII_ZERO
                          && character <= i2da_pkg::ASCII_NINE))
        else $error("character outside sign and digits");

    // A sign is never the final character
    a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (character == i2da_pkg::ASCII_MINUS) |-> !is_last)
        else $error("sign beat flagged as last");

    // A sign beat is followed by a digit, never by another sign
    a_sign_then_digit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && (character == i2da_pkg::ASCII_MINUS)
        |=> !(out_valid && (character == i2da_pkg::ASCII_MINUS)))
        else $error("two sign beats in a row");

    // The converter is busy right after it takes a number
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second number taken while converting");

endmodule

bind integer_to_decimal_ascii_top i2da_checker u_i2da_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .character (character),
    .is_last   (is_last)
);

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the 64-bit integer to decimal ASCII converter. Numbers in both
// modes go in through a randomly paced driver; every character that comes
// out is compared against text worked out here from the same number, while
// the output side stalls at random.
// ----------------------------------------------------------------------------
module testbench;

    localparam int NUM_RANDOM  = 450;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 200;

    // One number to convert
    typedef struct {
        logic                          mode;
        logic [i2da_pkg::VALUE_W-1:0]  raw;
    } number_t;

    // One character of expected text
    typedef struct {
        logic [i2da_pkg::CHAR_W-1:0] ch;
        logic                        is_end;
    } text_char_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_stall;
    logic                          command = i2da_pkg::CMD_UNSIGNED;
    logic [i2da_pkg::VALUE_W-1:0]  value = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic [i2da_pkg::CHAR_W-1:0]   character;
    logic                          is_last;

    number_t    number_q[$];
    text_char_t text_q[$];
    int         fail_cnt = 0;
    int         cycle_cnt = 0;
    int         gap_left = 0;
    int         stall_left = 0;
    bit         in_burst = 1'b0;
    bit         out_burst = 1'b0;

    integer_to_decimal_ascii_top i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .command   (command),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .character (character),
        .is_last   (is_last)
    );

    // Clock and reset
    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Decimal text of one number, appended to the expected text
    function automatic void predict_text(input logic mode,
                                         input logic [i2da_pkg::VALUE_W-1:0] raw);
        logic [i2da_pkg::VALUE_W-1:0] mag;
        logic                         neg;
        logic [i2da_pkg::CHAR_W-1:0]  digits[$];
        text_char_t                   tc;
        neg = (mode == i2da_pkg::CMD_SIGNED) && raw[i2da_pkg::VALUE_W-1];
        mag = neg ? (~raw + 64'd1) : raw;
        do
        begin
            digits.push_front(i2da_pkg::ASCII_ZERO + i2da_pkg::CHAR_W'(mag % 64'd10));
            mag = mag / 64'd10;
        end
        while (mag != 0);
        if (neg)
        begin
            tc.ch     = i2da_pkg::ASCII_MINUS;
            tc.is_end = 1'b0;
            text_q.push_back(tc);
        end
        foreach (digits[i])
        begin
            tc.ch     = digits[i];
            tc.is_end = (i == digits.size() - 1);
            text_q.push_back(tc);
        end
    endfunction

    function automatic logic [i2da_pkg::VALUE_W-1:0] pow10(input int k);
        logic [i2da_pkg::VALUE_W-1:0] p;
        p = 64'd1;
        repeat (k) p = p * 64'd10;
        return p;
    endfunction

    function automatic int draw_wait(input bit burst);
        return burst ? 0 : int'($urandom_range(0, 5));
    endfunction

    // Input driver: one beat per queued number, random gap after each
    always @(posedge clk)
    begin
        number_t nxt;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                predict_text(command, value);
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (number_q.size() > 0)
                begin
                    nxt = number_q.pop_front();
                    if ($urandom_range(0, 39) == 0)
                        in_burst = !in_burst;
                    in_valid <= 1'b1;
                    command  <= nxt.mode;
                    value    <= nxt.raw;
                    gap_left <= draw_wait(in_burst);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor: check each accepted beat, then stall at random
    always @(posedge clk)
    begin
        text_char_t exp_char;
        int         n;
        if (rst_n)
        begin
            n = stall_left;
            if (out_valid && !out_stall)
            begin
                if (text_q.size() == 0)
                begin
                    $display("%0t: unexpected beat, expected none, got char %h last %b",
                             $time, character, is_last);
                    fail_cnt++;
                end
                else
                begin
                    exp_char = text_q.pop_front();
                    if (character !== exp_char.ch)
                    begin
                        $display("%0t: character mismatch, expected %h, got %h",
                                 $time, exp_char.ch, character);
                        fail_cnt++;
                    end
                    if (is_last !== exp_char.is_end)
                    begin
                        $display("%0t: is_last mismatch, expected %b, got %b",
                                 $time, exp_char.is_end, is_last);
                        fail_cnt++;
                    end
                end
                if ($urandom_range(0, 99) == 0)
                    out_burst = !out_burst;
                n = draw_wait(out_burst);
            end
            if (n > 0)
            begin
                out_stall  <= 1'b1;
                stall_left <= n - 1;
            end
            else
            begin
                out_stall  <= 1'b0;
                stall_left <= 0;
            end
        end
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Stimulus and end of run
    initial
    begin
        number_t                       num;
        int                            kind;
        int                            k;
        logic [i2da_pkg::VALUE_W-1:0]  p;

        // Directed: zero, extremes, digit-count boundaries, sign handling
        number_q.push_back('{i2da_pkg::CMD_UNSIGNED, 64'd0});
        number_q.push_back('{i2da_pkg::CMD_SIGNED,   64'd0});
        number_q.push_back('{i2da_pkg::CMD_UNSIGNED, 64'hFFFF_FFFF_FFFF_FFFF});
        number_q.push_back('{i2da_pkg::CMD_SIGNED,   64'hFFFF_FFFF_FFFF_FFFF});
        number_q.push_back('{i2da_pkg::CMD_SIGNED,   64'h8000_0000_0000_0000});
        number_q.push_back('{i2da_pkg::CMD_UNSIGNED, 64'h8000_0000_0000_0000});
        number_q.push_back('{i2da_pkg::CMD_SIGNED,   64'h7FFF_FFFF_FFFF_FFFF});
        number_q.push_back('{i2da_pkg::CMD_UNSIGNED, 64'h7FFF_FFFF_FFFF_FFFF});
        number_q.push_back('{i2da_pkg::CMD_UNSIGNED, 64'd1});
        number_q.push_back('{i2da_pkg::CMD_SIGNED,   64'd1});
        number_q.push_back('{i2da_pkg::CMD_UNSIGNED, 64'd9});
        number_q.push_back('{i2da_pkg::CMD_UNSIGNED, 64'd10});
        number_q.push_back('{i2da_pkg::CMD_SIGNED,   -64'sd10});
        number_q.push_back('{i2da_pkg::CMD_UNSIGNED, 64'd99});
        number_q.push_back('{i2da_pkg::CMD_UNSIGNED, 64'd100});
        number_q.push_back('{i2da_pkg::CMD_UNSIGNED, pow10(19) - 64'd1});
        number_q.push_back('{i2da_pkg::CMD_UNSIGNED, pow10(19)});
        number_q.push_back('{i2da_pkg::CMD_SIGNED,   -pow10(18)});
        number_q.push_back('{i2da_pkg::CMD_UNSIGNED, 64'h5555_5555_5555_5555});
        number_q.push_back('{i2da_pkg::CMD_SIGNED,   64'hAAAA_AAAA_AAAA_AAAA});

        // Random: full patterns, bounded digit counts, powers of ten, small values
        for (int i = 0; i < NUM_RANDOM; i++)
        begin
            num.mode = 1'($urandom_range(0, 1));
            kind     = $urandom_range(0, 3);
            k        = $urandom_range(1, 19);
            p        = pow10(k);
            case (kind)
                0: num.raw = {$urandom, $urandom};
                1: num.raw = {$urandom, $urandom} % p;
                2: num.raw = p - 64'($urandom_range(0, 1));
                default: num.raw = 64'($urandom_range(0, 20));
            endcase
            if (kind != 0 && num.mode == i2da_pkg::CMD_SIGNED && $urandom_range(0, 1) == 1)
                num.raw = -num.raw;
            number_q.push_back(num);
        end

        // Wait for all numbers to be taken and all text to come back
        @(negedge clk);
        while (number_q.size() > 0 || in_valid || text_q.size() > 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (fail_cnt == 0 && text_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
